FILE: sv/wecs_pkg.sv
// shared types and codes for the watched entry change settler
package wecs_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 6;
    localparam int SIZE_W = 64;
    localparam int TIME_W = 64;
    localparam int KIND_W = 2;

    // entries that the index field can name
    localparam int IDX_SPAN = 2 ** IDX_W;

    localparam logic [CMD_W-1:0] CMD_OBSERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WATCH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNWATCH = 2'd2;

    localparam logic [KIND_W-1:0] EV_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] EV_CREATED  = 2'd1;
    localparam logic [KIND_W-1:0] EV_MODIFIED = 2'd2;
    localparam logic [KIND_W-1:0] EV_REMOVED  = 2'd3;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic                     dir_born;
        logic                     present;
        logic [SIZE_W-1:0]        size;
        logic signed [TIME_W-1:0] mtime;
        logic                     pending;
        logic [SIZE_W-1:0]        pend_size;
        logic signed [TIME_W-1:0] pend_time;
    } entry_t;

endpackage

FILE: sv/wecs_in_if.sv
// command channel: valid, ready and one command item
interface wecs_in_if;
    import wecs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         entry_index;
    logic                     from_dir_walk;
    logic                     seen_present;
    logic [SIZE_W-1:0]        seen_size;
    logic signed [TIME_W-1:0] seen_time;

    modport source (
        output valid, cmd, entry_index, from_dir_walk, seen_present, seen_size, seen_time,
        input  ready
    );

    modport sink (
        input  valid, cmd, entry_index, from_dir_walk, seen_present, seen_size, seen_time,
        output ready
    );
endinterface

FILE: sv/wecs_out_if.sv
// event channel: valid, ready and one event item
interface wecs_out_if;
    import wecs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        event_kind;
    logic [IDX_W-1:0]         event_index;
    logic [SIZE_W-1:0]        event_size;
    logic signed [TIME_W-1:0] event_time;
    logic                     entry_dropped;
    logic                     status;

    modport source (
        output valid, event_kind, event_index, event_size, event_time, entry_dropped, status,
        input  ready
    );

    modport sink (
        input  valid, event_kind, event_index, event_size, event_time, entry_dropped, status,
        output ready
    );
endinterface

FILE: sv/watched_entry_change_settler.sv
// watched entry change settler: entry table with two-poll settling of changes
//
// Keeps a table of watched entries. Each command transfer on item (watch,
// unwatch or observe) yields exactly one event transfer on result. An
// observation that differs from the last reported state is held as pending
// and is reported as created or modified only when the next observation of
// the same entry agrees with it; an absent observation of a present entry
// reports removed at once. Directory-born entries that end up absent with
// nothing pending leave the table and are flagged as dropped. Each item is
// worked in order: at the transfer the entry memory is read into a register
// (synchronous read); the modify step then changes the entry, writes it back
// and loads the result register. One item is in work at a time, which also
// keeps reads and write-backs of the same entry apart. The next item is
// taken while a finished event still waits in the result register; an item
// stays in its modify step only while that register is full and not taken.
// Watched flags reset to clear at once, so no clearing pass follows reset.
module watched_entry_change_settler #(
    parameter int ENTRIES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    wecs_in_if.sink    item,
    wecs_out_if.source result
);
    import wecs_pkg::*;

    // only indexes the field can carry get storage
    localparam int DEPTH = (ENTRIES < IDX_SPAN) ? ENTRIES : IDX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // entry memory, read data registered
    entry_t entry_mem [DEPTH];
    entry_t rd_reg;

    logic             state_reg, state_next;
    logic [DEPTH-1:0] valid_reg, valid_next;

    // captured item
    logic [CMD_W-1:0]         cmd_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     dir_reg;
    logic                     seen_reg;
    logic [SIZE_W-1:0]        ssize_reg;
    logic signed [TIME_W-1:0] stime_reg;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]        kind_reg;
    logic [IDX_W-1:0]         eidx_reg;
    logic [SIZE_W-1:0]        esize_reg;
    logic signed [TIME_W-1:0] etime_reg;
    logic                     dropped_reg;
    logic                     status_reg;

    logic                     accept;
    logic                     commit;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic                     inrange;
    logic                     watched;

    // outcome of the modify step
    entry_t                   new_entry;
    logic                     mem_we;
    logic                     vset;
    logic                     vclr;
    logic [KIND_W-1:0]        kind;
    logic [SIZE_W-1:0]        esize;
    logic signed [TIME_W-1:0] etime;
    logic                     dropped;
    logic                     status;

    // one item at a time: take a transfer only between items
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    // the modify step finishes once the result register can take the event
    assign commit     = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);

    assign rd_addr = item.entry_index[AW-1:0];
    assign wr_addr = idx_reg[AW-1:0];
    assign inrange = int'(idx_reg) < ENTRIES;
    assign watched = inrange && valid_reg[wr_addr];

    // read port: only at the transfer, so the data holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= entry_mem[rd_addr];
        end
    end

    // write port
    always_ff @(posedge clk)
    begin
        if (commit && mem_we)
        begin
            entry_mem[wr_addr] <= new_entry;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.cmd;
            idx_reg   <= item.entry_index;
            dir_reg   <= item.from_dir_walk;
            seen_reg  <= item.seen_present;
            ssize_reg <= item.seen_size;
            stime_reg <= item.seen_time;
        end
    end

    // modify step on the entry just read
    always_comb
    begin
        new_entry = rd_reg;
        mem_we    = 1'b0;
        vset      = 1'b0;
        vclr      = 1'b0;
        kind      = EV_NONE;
        esize     = '0;
        etime     = '0;
        dropped   = 1'b0;
        status    = 1'b0;
        case (cmd_reg)
            CMD_WATCH:
            begin
                // watch of a watched entry keeps its state
                if (inrange && !watched)
                begin
                    vset      = 1'b1;
                    mem_we    = 1'b1;
                    new_entry = '0;
                    new_entry.dir_born = dir_reg;
                end
            end
            CMD_UNWATCH:
            begin
                if (watched)
                begin
                    vclr = 1'b1;
                end
                else
                begin
                    status = 1'b1;
                end
            end
            CMD_OBSERVE:
            begin
                if (!watched)
                begin
                    status = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (!seen_reg)
                    begin
                        new_entry.pending = 1'b0;
                        if (rd_reg.present)
                        begin
                            new_entry.present = 1'b0;
                            new_entry.size    = '0;
                            new_entry.mtime   = '0;
                            kind              = EV_REMOVED;
                        end
                    end
                    else if (rd_reg.present && ssize_reg == rd_reg.size
                             && stime_reg == rd_reg.mtime)
                    begin
                        // back to the reported state
                        new_entry.pending = 1'b0;
                    end
                    else if (!rd_reg.pending || rd_reg.pend_size != ssize_reg
                             || rd_reg.pend_time != stime_reg)
                    begin
                        // new candidate, wait for a second look
                        new_entry.pending   = 1'b1;
                        new_entry.pend_size = ssize_reg;
                        new_entry.pend_time = stime_reg;
                    end
                    else
                    begin
                        // two polls agree: settle and report
                        kind              = rd_reg.present ? EV_MODIFIED : EV_CREATED;
                        esize             = ssize_reg;
                        etime             = stime_reg;
                        new_entry.present = 1'b1;
                        new_entry.size    = ssize_reg;
                        new_entry.mtime   = stime_reg;
                        new_entry.pending = 1'b0;
                    end
                    // directory-born entry with nothing left to track
                    if (rd_reg.dir_born && !new_entry.present && !new_entry.pending)
                    begin
                        vclr    = 1'b1;
                        dropped = 1'b1;
                    end
                end
            end
            default:
            begin
                // unknown command: no effect
            end
        endcase
    end

    // watched flags
    always_comb
    begin
        valid_next = valid_reg;
        if (commit && vset)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        else if (commit && vclr)
        begin
            valid_next[wr_addr] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            kind_reg    <= kind;
            eidx_reg    <= idx_reg;
            esize_reg   <= esize;
            etime_reg   <= etime;
            dropped_reg <= dropped;
            status_reg  <= status;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.event_kind    = kind_reg;
    assign result.event_index   = eidx_reg;
    assign result.event_size    = esize_reg;
    assign result.event_time    = etime_reg;
    assign result.entry_dropped = dropped_reg;
    assign result.status        = status_reg;

`ifndef ASSERT_OFF
    // an accepted item blocks the next transfer in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("item taken while previous item still in work");

    // an unwatched entry never reports a change
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.event_kind == EV_NONE)
        else $error("event reported for an unwatched entry");

    // a drop comes only with nothing reported or with a removal
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.entry_dropped
        |-> result.event_kind == EV_NONE || result.event_kind == EV_REMOVED)
        else $error("entry dropped on a created or modified event");

    // a finished item loads the result register and frees the block
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished item did not load the result register");
`endif

endmodule

FILE: sim/watched_entry_change_settler_tb.sv
// testbench for the watched entry change settler: directed table, random traffic, event checks
`timescale 1ns / 100ps

module watched_entry_change_settler_tb;
    import wecs_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    // command code the block does not know; it must leave everything alone
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [SIZE_W-1:0] SIZE_ALL = '1;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [TIME_W-1:0] TIME_NEG1 = -64'sd1;

    // one command transfer as the sender drives it
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         idx;
        logic                     dir;
        logic                     present;
        logic [SIZE_W-1:0]        size;
        logic signed [TIME_W-1:0] mtime;
    } command_t;

    // one event transfer as the block should produce it
    typedef struct {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         idx;
        logic [SIZE_W-1:0]        size;
        logic signed [TIME_W-1:0] mtime;
        logic                     dropped;
        logic                     status;
    } change_report_t;

    // directed row: a command plus, where obvious, the event typed in by hand
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [IDX_W-1:0]         idx;
        logic                     dir;
        logic                     present;
        logic [SIZE_W-1:0]        size;
        logic signed [TIME_W-1:0] mtime;
        logic                     typed;
        logic [KIND_W-1:0]        kind;
        logic [SIZE_W-1:0]        ev_size;
        logic signed [TIME_W-1:0] ev_time;
        logic                     dropped;
        logic                     status;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // observe and unwatch before anything is watched are refused
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, SIZE_ALL, TIME_MIN,  1'b1, EV_NONE, 0, 0, 1'b0, 1'b1},
        '{CMD_UNWATCH, 6'd63, 1'b1, 1'b1, SIZE_ALL, TIME_MAX,  1'b1, EV_NONE, 0, 0, 1'b0, 1'b1},
        // unknown command does nothing and is not an error
        '{CMD_UNUSED,  6'd5,  1'b1, 1'b1, SIZE_ALL, TIME_NEG1, 1'b1, EV_NONE, 0, 0, 1'b0, 1'b0},
        // watch, then a second watch that must not make the entry directory-born
        '{CMD_WATCH,   6'd0,  1'b0, 1'b0, 0, 0,                1'b1, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_WATCH,   6'd0,  1'b1, 1'b1, 5, 5,                1'b1, EV_NONE, 0, 0, 1'b0, 1'b0},
        // extremes: first poll goes pending, the agreeing one reports created
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, SIZE_ALL, TIME_MIN,  1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, SIZE_ALL, TIME_MIN,  1'b1, EV_CREATED, SIZE_ALL,
          TIME_MIN, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, SIZE_ALL, TIME_MIN,  1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, 0, TIME_MAX,         1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b1, 0, TIME_MAX,         1'b1, EV_MODIFIED, 0, TIME_MAX,
          1'b0, 1'b0},
        // absent on a present entry reports removed at once, size and time ignored
        '{CMD_OBSERVE, 6'd0,  1'b0, 1'b0, SIZE_ALL, TIME_MAX,  1'b1, EV_REMOVED, 0, 0, 1'b0, 1'b0},
        // directory-born entry: pending then absent gets dropped
        '{CMD_WATCH,   6'd63, 1'b1, 1'b0, 0, 0,                1'b1, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b1, 5, TIME_NEG1,        1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b0, 0, 0,                1'b1, EV_NONE, 0, 0, 1'b1, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b1, 5, TIME_NEG1,        1'b1, EV_NONE, 0, 0, 1'b0, 1'b1},
        // directory-born entry created, then removed and dropped in one step
        '{CMD_WATCH,   6'd63, 1'b1, 1'b0, 0, 0,                1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b1, 7, 7,                1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b1, 7, 7,                1'b1, EV_CREATED, 7, 7, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd63, 1'b0, 1'b0, 7, 7,                1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        // a differing poll replaces the pending one
        '{CMD_WATCH,   6'd1,  1'b0, 1'b0, 0, 0,                1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd1,  1'b0, 1'b1, 10, 100,             1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd1,  1'b0, 1'b1, 11, 100,             1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_OBSERVE, 6'd1,  1'b0, 1'b1, 11, 100,             1'b1, EV_CREATED, 11, 100,
          1'b0, 1'b0},
        // unwatch frees the entry, a second unwatch is refused
        '{CMD_UNWATCH, 6'd0,  1'b0, 1'b0, 0, 0,                1'b0, EV_NONE, 0, 0, 1'b0, 1'b0},
        '{CMD_UNWATCH, 6'd0,  1'b0, 1'b0, 0, 0,                1'b1, EV_NONE, 0, 0, 1'b0, 1'b1}
    };

    logic clk;
    logic rst_n;

    wecs_in_if  cmd_bus ();
    wecs_out_if evt_bus ();

    watched_entry_change_settler #(
        .ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (cmd_bus.sink),
        .result (evt_bus.source)
    );

    // predictor state: watched flags and the entry contents
    logic   tracked [IDX_SPAN];
    entry_t entry_state [IDX_SPAN];

    // last present poll per entry, so random polls can repeat it and settle
    logic [SIZE_W-1:0]        last_size [IDX_SPAN];
    logic signed [TIME_W-1:0] last_time [IDX_SPAN];

    // events still owed by the block, oldest first
    change_report_t owed_events [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_events = 0;
    int unsigned n_created = 0;
    int unsigned n_modified = 0;
    int unsigned n_removed = 0;
    int unsigned n_dropped = 0;
    int unsigned n_refused = 0;

    int unsigned sink_stall = 0;
    int unsigned sink_quiet = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // idle length: mostly short, now and then long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // 64-bit value biased toward edges and small numbers
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // apply one command to the predictor table and return the event it owes
    function automatic change_report_t settle_command(input command_t c);
        change_report_t ev;
        entry_t         e;
        logic           in_range;
        logic           known;
        ev.kind    = EV_NONE;
        ev.idx     = c.idx;
        ev.size    = '0;
        ev.mtime   = '0;
        ev.dropped = 1'b0;
        ev.status  = 1'b0;
        in_range = (int'(c.idx) < TABLE_DEPTH);
        known    = in_range && tracked[c.idx];
        case (c.cmd)
            CMD_WATCH:
            begin
                // a second watch keeps the entry as it is
                if (in_range && !known)
                begin
                    tracked[c.idx]              = 1'b1;
                    entry_state[c.idx]          = '0;
                    entry_state[c.idx].dir_born = c.dir;
                end
            end
            CMD_UNWATCH:
            begin
                if (known)
                    tracked[c.idx] = 1'b0;
                else
                    ev.status = 1'b1;
            end
            CMD_OBSERVE:
            begin
                if (!known)
                    ev.status = 1'b1;
                else
                begin
                    e = entry_state[c.idx];
                    if (!c.present)
                    begin
                        // absence drops any pending poll, reports removal if it was there
                        e.pending = 1'b0;
                        if (e.present)
                        begin
                            e.present = 1'b0;
                            e.size    = '0;
                            e.mtime   = '0;
                            ev.kind   = EV_REMOVED;
                        end
                    end
                    else if (e.present && c.size == e.size && c.mtime == e.mtime)
                        e.pending = 1'b0;
                    else if (!e.pending || e.pend_size != c.size || e.pend_time != c.mtime)
                    begin
                        e.pending   = 1'b1;
                        e.pend_size = c.size;
                        e.pend_time = c.mtime;
                    end
                    else
                    begin
                        // second agreeing poll settles the change
                        ev.kind   = e.present ? EV_MODIFIED : EV_CREATED;
                        ev.size   = c.size;
                        ev.mtime  = c.mtime;
                        e.present = 1'b1;
                        e.size    = c.size;
                        e.mtime   = c.mtime;
                        e.pending = 1'b0;
                    end
                    if (e.dir_born && !e.present && !e.pending)
                    begin
                        tracked[c.idx] = 1'b0;
                        ev.dropped     = 1'b1;
                    end
                    entry_state[c.idx] = e;
                end
            end
            default:
            begin
            end
        endcase
        return ev;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got 0x%h expected 0x%h", $realtime, what, got, want);
    endtask

    // drive one command after a gap and hold it until the transfer happens;
    // valid is only lowered when a gap follows, never in the step it is raised
    task automatic issue_command(input command_t c, input int unsigned gap, input logic typed,
                                 input change_report_t fixed);
        change_report_t ev;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_bus.valid          <= 1'b1;
        cmd_bus.cmd            <= c.cmd;
        cmd_bus.entry_index    <= c.idx;
        cmd_bus.from_dir_walk  <= c.dir;
        cmd_bus.seen_present   <= c.present;
        cmd_bus.seen_size      <= c.size;
        cmd_bus.seen_time      <= c.mtime;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        // predictor always runs so its table stays in step with the block
        ev = settle_command(c);
        if (c.cmd == CMD_OBSERVE && c.present)
        begin
            last_size[c.idx] = c.size;
            last_time[c.idx] = c.mtime;
        end
        owed_events.insert(owed_events.size(), typed ? fixed : ev);
    endtask

    // event sink: ready drops for random stalls, with stretches of none
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            evt_bus.ready <= 1'b0;
            sink_stall--;
        end
        else
        begin
            evt_bus.ready <= 1'b1;
            if (sink_quiet > 0)
                sink_quiet--;
            else if ($urandom_range(0, 3) == 0)
            begin
                sink_stall = idle_span();
                if ($urandom_range(0, 15) == 0)
                    sink_quiet = $urandom_range(20, 80);
            end
        end
    end

    // event checker: every transfer on the event side against the oldest owed event
    always @(posedge clk)
    begin : check_events
        change_report_t want;
        if (rst_n && evt_bus.valid && evt_bus.ready)
        begin
            n_events++;
            if (owed_events.size() == 0)
                report_mismatch("event with nothing owed, index", 64'(evt_bus.event_index), '0);
            else
            begin
                want = owed_events.pop_front();
                if (evt_bus.event_kind !== want.kind)
                    report_mismatch("event_kind", 64'(evt_bus.event_kind), 64'(want.kind));
                if (evt_bus.event_index !== want.idx)
                    report_mismatch("event_index", 64'(evt_bus.event_index), 64'(want.idx));
                if (evt_bus.event_size !== want.size)
                    report_mismatch("event_size", evt_bus.event_size, want.size);
                if (evt_bus.event_time !== want.mtime)
                    report_mismatch("event_time", evt_bus.event_time, want.mtime);
                if (evt_bus.entry_dropped !== want.dropped)
                    report_mismatch("entry_dropped", 64'(evt_bus.entry_dropped),
                                    64'(want.dropped));
                if (evt_bus.status !== want.status)
                    report_mismatch("status", 64'(evt_bus.status), 64'(want.status));
            end
            case (evt_bus.event_kind)
                EV_CREATED:  n_created++;
                EV_MODIFIED: n_modified++;
                EV_REMOVED:  n_removed++;
                default:
                begin
                end
            endcase
            if (evt_bus.entry_dropped === 1'b1)
                n_dropped++;
            if (evt_bus.status === 1'b1)
                n_refused++;
        end
    end

    // run limit, far above the slowest correct run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events still owed", cycle_count,
                     owed_events.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        command_t       c;
        change_report_t fixed;
        int unsigned    gap;
        int unsigned    src_quiet;
        int unsigned    roll;

        src_quiet              = 0;
        rst_n                  = 1'b0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.cmd            = CMD_OBSERVE;
        cmd_bus.entry_index    = '0;
        cmd_bus.from_dir_walk  = 1'b0;
        cmd_bus.seen_present   = 1'b0;
        cmd_bus.seen_size      = '0;
        cmd_bus.seen_time      = '0;
        evt_bus.ready          = 1'b0;
        for (int i = 0; i < IDX_SPAN; i++)
        begin
            tracked[i]     = 1'b0;
            entry_state[i] = '0;
            last_size[i]   = '0;
            last_time[i]   = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r])
        begin
            c.cmd         = directed_rows[r].cmd;
            c.idx         = directed_rows[r].idx;
            c.dir         = directed_rows[r].dir;
            c.present     = directed_rows[r].present;
            c.size        = directed_rows[r].size;
            c.mtime       = directed_rows[r].mtime;
            fixed.kind    = directed_rows[r].kind;
            fixed.idx     = directed_rows[r].idx;
            fixed.size    = directed_rows[r].ev_size;
            fixed.mtime   = directed_rows[r].ev_time;
            fixed.dropped = directed_rows[r].dropped;
            fixed.status  = directed_rows[r].status;
            gap = ($urandom_range(0, 1) == 0) ? 0 : idle_span();
            issue_command(c, gap, directed_rows[r].typed, fixed);
        end

        // random traffic: mostly polls on a few busy entries, repeated often
        // enough to settle; watches, unwatches and unknown codes mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 250 == 125)
            begin
                // let the block drain completely before going on
                @(negedge clk);
                cmd_bus.valid <= 1'b0;
                while (owed_events.size() != 0)
                    @(posedge clk);
            end

            c.idx     = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 63))
                                                    : IDX_W'($urandom_range(0, 7));
            c.dir     = 1'($urandom_range(0, 1));
            c.present = 1'($urandom_range(0, 1));
            c.size    = rand_word();
            c.mtime   = rand_word();
            roll      = $urandom_range(0, 99);
            if (roll < 8)
                c.cmd = CMD_WATCH;
            else if (roll < 14)
                c.cmd = CMD_UNWATCH;
            else if (roll < 17)
                c.cmd = CMD_UNUSED;
            else
            begin
                c.cmd = CMD_OBSERVE;
                // polls on unwatched entries are mostly turned into watches
                if (!tracked[c.idx] && $urandom_range(0, 9) < 7)
                    c.cmd = CMD_WATCH;
                else
                begin
                    c.present = ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 9) < 6)
                    begin
                        c.size  = last_size[c.idx];
                        c.mtime = last_time[c.idx];
                    end
                    else if ($urandom_range(0, 3) == 0)
                        c.mtime = last_time[c.idx];
                end
            end

            if (src_quiet > 0)
            begin
                gap = 0;
                src_quiet--;
            end
            else
            begin
                gap = ($urandom_range(0, 99) < 45) ? 0 : idle_span();
                if ($urandom_range(0, 29) == 0)
                    src_quiet = $urandom_range(20, 60);
            end
            issue_command(c, gap, 1'b0, fixed);
        end

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (owed_events.size() != 0)
            @(posedge clk);
        // keep the clock running so a stray extra event would still be seen
        repeat (10) @(posedge clk);

        $display("covered %0d directed and %0d random commands, %0d events checked",
                 DIRECTED_ROWS, RANDOM_ITEMS, n_events);
        $display("events: %0d created, %0d modified, %0d removed, %0d dropped, %0d refused",
                 n_created, n_modified, n_removed, n_dropped, n_refused);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
